// ===== rtl/kwm_pkg.sv =====
// Package for the k-way merge unit: payload structs, operation and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package kwm_pkg;

    // Default configuration of the unit.
    localparam int NUM_LISTS_DEF   = 8;
    localparam int LIST_DEPTH_DEF  = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    // Operation codes carried by an input transaction.
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_PULL   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_RSVD   = 2'd3
    } t_opcode;

    // Status codes carried by a result transaction.
    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMIT  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } t_status;

    // Input transaction payload.
    typedef struct packed {
        t_opcode            opcode;
        logic [2:0]         list_index;
        logic signed [31:0] value;
    } t_in_item;

    // Result transaction payload.
    typedef struct packed {
        logic signed [31:0] merged_value;
        t_status            status;
        logic               final_value;
    } t_out_item;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_LAST,
        S_COMMIT,
        S_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // capture the accepted input transaction
        logic decode;     // execute append/clear, or start a pull
        logic scan_step;  // read the head of the current list
        logic commit;     // advance the winning list and build the result
        logic out_load;   // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pull_work;  // the held item is a pull and elements remain
        logic scan_last;  // the scan is at the last list
        logic out_free;   // the output register can take a result
    } t_dp_sts;

endpackage

// ===== rtl/kwm_ctrl.sv =====
// Controller of the k-way merge unit: sequences decode, head scan, commit
// and result hand-off. Depends on kwm_pkg.
module kwm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  kwm_pkg::t_dp_sts i_sts,
    output kwm_pkg::t_dp_cmd o_cmd,
    output logic             o_in_ready
);

    kwm_pkg::t_state r_state;
    kwm_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kwm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            kwm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = kwm_pkg::S_DECODE;
                end
            end
            kwm_pkg::S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state = i_sts.pull_work ? kwm_pkg::S_SCAN : kwm_pkg::S_RESULT;
            end
            kwm_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = kwm_pkg::S_LAST;
                end
            end
            kwm_pkg::S_LAST: begin
                // The head read in the final scan cycle is compared here.
                n_state = kwm_pkg::S_COMMIT;
            end
            kwm_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = kwm_pkg::S_RESULT;
            end
            kwm_pkg::S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = kwm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kwm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/kwm_dp.sv =====
// Datapath of the k-way merge unit: list storage memory, per-list length and
// read counters, head comparator and output register. Depends on kwm_pkg.
module kwm_dp #(
    parameter int NUM_LISTS   = kwm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH  = kwm_pkg::LIST_DEPTH_DEF,
    parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kwm_pkg::t_dp_cmd   i_cmd,
    input  kwm_pkg::t_in_item  i_in_item,
    input  logic               i_out_ready,
    output kwm_pkg::t_dp_sts   o_sts,
    output logic               o_out_valid,
    output kwm_pkg::t_out_item o_out_item
);

    localparam int LW = $clog2(NUM_LISTS);
    localparam int PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int RW = $clog2(NUM_LISTS * LIST_DEPTH + 1);
    localparam int MD = NUM_LISTS * (2 ** PW);

    // List storage, addressed by {list, position}.
    logic [VALUE_WIDTH-1:0] mem [MD];

    kwm_pkg::t_in_item      r_item;
    logic [CW-1:0]          r_len [NUM_LISTS];
    logic [CW-1:0]          r_pos [NUM_LISTS];
    logic [RW-1:0]          r_remaining;
    logic [LW-1:0]          r_scan;
    logic                   r_rd_vld;
    logic [LW-1:0]          r_rd_list;
    logic [CW-1:0]          r_rd_pos;
    logic [VALUE_WIDTH-1:0] r_rd_data;
    logic                   r_found;
    logic [LW-1:0]          r_best_list;
    logic [CW-1:0]          r_best_pos;
    logic [VALUE_WIDTH-1:0] r_best_val;
    kwm_pkg::t_out_item     r_res;
    kwm_pkg::t_out_item     n_res;
    kwm_pkg::t_out_item     r_out;
    logic                   r_out_vld;

    logic [LW-1:0]          sel_list;
    logic                   in_range;
    logic [LW-1:0]          len_addr;
    logic [CW-1:0]          len_rd;
    logic [CW-1:0]          pos_rd;
    logic                   can_append;
    logic                   head_vld;
    logic                   do_append;
    logic                   do_clear;
    logic                   do_pull;
    logic signed [63:0]     ext_val;
    logic [63:0]            best_wide;
    logic                   better;

    // Operand selection; the length table has a single read address.
    assign sel_list   = LW'(r_item.list_index);
    assign in_range   = int'(r_item.list_index) < NUM_LISTS;
    assign len_addr   = i_cmd.decode ? sel_list : r_scan;
    assign len_rd     = r_len[len_addr];
    assign pos_rd     = r_pos[r_scan];
    assign can_append = in_range && (len_rd < CW'(LIST_DEPTH));
    assign head_vld   = pos_rd < len_rd;
    assign do_append  = i_cmd.decode && (r_item.opcode == kwm_pkg::OP_APPEND) && can_append;
    assign do_clear   = i_cmd.decode && (r_item.opcode == kwm_pkg::OP_CLEAR);
    assign do_pull    = i_cmd.decode && (r_item.opcode == kwm_pkg::OP_PULL);
    assign ext_val    = 64'(r_item.value);
    assign best_wide  = 64'(r_best_val);
    assign better     = !r_found || ($signed(r_rd_data) < $signed(r_best_val));

    // Status toward the controller.
    assign o_sts.pull_work = (r_item.opcode == kwm_pkg::OP_PULL) && (r_remaining != '0);
    assign o_sts.scan_last = r_scan == LW'(NUM_LISTS - 1);
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    // Memory: append writes at the tail, the scan reads the current head.
    always_ff @(posedge i_clk) begin
        if (do_append) begin
            mem[{sel_list, len_rd[PW-1:0]}] <= ext_val[VALUE_WIDTH-1:0];
        end
        if (i_cmd.scan_step) begin
            r_rd_data <= mem[{r_scan, pos_rd[PW-1:0]}];
        end
    end

    // Result of the held item.
    always_comb begin
        n_res = r_res;
        if (i_cmd.decode) begin
            n_res.merged_value = '0;
            n_res.final_value  = 1'b0;
            case (r_item.opcode)
                kwm_pkg::OP_APPEND: begin
                    n_res.status = can_append ? kwm_pkg::STAT_DONE : kwm_pkg::STAT_FULL;
                end
                kwm_pkg::OP_PULL: begin
                    n_res.status = kwm_pkg::STAT_EMPTY;
                end
                default: begin
                    n_res.status = kwm_pkg::STAT_DONE;
                end
            endcase
        end
        if (i_cmd.commit) begin
            n_res.merged_value = best_wide[31:0];
            n_res.status       = kwm_pkg::STAT_EMIT;
            n_res.final_value  = r_remaining == RW'(1);
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_item;
        end
        r_res <= n_res;
        if (i_cmd.scan_step) begin
            r_rd_list <= r_scan;
            r_rd_pos  <= pos_rd;
        end
        if (r_rd_vld && better) begin
            r_best_list <= r_rd_list;
            r_best_pos  <= r_rd_pos;
            r_best_val  <= r_rd_data;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    // Counters and control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_len[i] <= '0;
                r_pos[i] <= '0;
            end
            r_remaining <= '0;
            r_scan      <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_step && head_vld;
            if (do_append) begin
                r_len[sel_list] <= len_rd + CW'(1);
                r_remaining     <= r_remaining + RW'(1);
            end
            if (do_clear) begin
                for (int i = 0; i < NUM_LISTS; i++) begin
                    r_len[i] <= '0;
                    r_pos[i] <= '0;
                end
                r_remaining <= '0;
            end
            if (do_pull) begin
                r_scan  <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_step && !o_sts.scan_last) begin
                r_scan <= r_scan + LW'(1);
            end
            if (r_rd_vld) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_pos[r_best_list] <= r_best_pos + CW'(1);
                r_remaining        <= r_remaining - RW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

// ===== rtl/k_way_merge_unit.sv =====
// K-way merge unit: appends values to up to NUM_LISTS lists and pulls the
// smallest remaining head on request. A pull scans the list heads one per cycle
// through the single read port of the list memory. One transaction is in work
// at a time, and a finished result sits in an output register while the next
// transaction is accepted. The list memory needs no clearing pass after reset:
// per-list counters mark a head valid only within the written entries. Ties
// among equal heads go to the lowest list.
//
// Top level; depends on kwm_pkg, kwm_ctrl and kwm_dp.
module k_way_merge_unit #(
    parameter int NUM_LISTS   = kwm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH  = kwm_pkg::LIST_DEPTH_DEF,
    parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  kwm_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output kwm_pkg::t_out_item o_out_item
);

    kwm_pkg::t_dp_cmd w_cmd;
    kwm_pkg::t_dp_sts w_sts;

    // Sequencer.
    kwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready)
    );

    // Storage, counters and comparator.
    kwm_dp #(
        .NUM_LISTS   (NUM_LISTS),
        .LIST_DEPTH  (LIST_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/kwm_checker.sv =====
// Port-level checks for the k-way merge unit, attached by bind.
// Depends on kwm_pkg and k_way_merge_unit.
module kwm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input kwm_pkg::t_out_item o_out_item
);

    // A stalled result transaction is held unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result transaction changed while stalled");

    // Only one input transaction is in work: ready drops after an acceptance.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while a transaction is in work");

    // The final flag is only set on an emitted value.
    a_final_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.final_value |->
            o_out_item.status == kwm_pkg::STAT_EMIT)
        else $error("final flag without an emitted value");

    // A nonzero value is only reported on an emit.
    a_value_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.merged_value != '0) |->
            o_out_item.status == kwm_pkg::STAT_EMIT)
        else $error("nonzero value without an emitted value");

endmodule

bind k_way_merge_unit kwm_checker u_kwm_checker (.*);
